// ===== design/modbus_write_regs_frame_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// modbus write regs frame encoder assertion macros
// concurrent checks on clk with rst as disable, compiled out by NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef MODBUS_WRITE_REGS_FRAME_ENCODER_MACROS_SVH
`define MODBUS_WRITE_REGS_FRAME_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge out of reset
`define MBWR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define MBWR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MBWR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MBWR_ASSERT(lbl, cond, msg)
`define MBWR_ASSERT_IMP(lbl, ante, cons, msg)
`define MBWR_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/mbwr_enc_pkg.sv =====
// ----------------------------------------------------------------------------
// mbwr_enc_pkg
// shared constants, queue entry type, byte sequencer states and crc helper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbwr_enc_pkg;

  localparam int MAX_REGISTERS = 123;
  localparam int QTY_W         = 7;
  localparam logic [7:0]  FUNC_WRITE_MULTI = 8'h10;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified word on its way to the serializer
  typedef struct packed {
    logic              start;      // opens a frame, header goes first
    logic              last_word;  // crc follows this word
    logic              reply;      // frame is not broadcast
    logic [7:0]        addr;
    logic [15:0]       saddr;
    logic [QTY_W-1:0]  qty;        // already saturated
    logic [15:0]       word;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // byte position within a queue entry
  typedef enum logic [3:0] {
    SEL_START,
    SEL_ADDR,
    SEL_FUNC,
    SEL_SA_HI,
    SEL_SA_LO,
    SEL_QTY_HI,
    SEL_QTY_LO,
    SEL_BCNT,
    SEL_WORD_HI,
    SEL_WORD_LO,
    SEL_CRC_LO,
    SEL_CRC_HI
  } byte_sel_t;

  // crc-16/modbus over one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/mbwr_enc_front.sv =====
// ----------------------------------------------------------------------------
// mbwr_enc_front
// accepts input words, tracks the open frame and queues classified commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modbus_write_regs_frame_encoder_macros.svh"

module mbwr_enc_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic                    start_req,
  input  logic [7:0]              slave_addr,
  input  logic [15:0]             start_addr,
  input  logic [6:0]              register_qty,
  input  logic [15:0]             data_word,
  input  mbwr_enc_pkg::q_status_t q_status,
  output logic                    push,
  output mbwr_enc_pkg::cmd_t      push_cmd
);

  logic                           frame_open;
  logic [mbwr_enc_pkg::QTY_W-1:0] words_left;
  logic                           reply_flag;

  logic                           accept;
  logic [mbwr_enc_pkg::QTY_W-1:0] qty_sat;
  logic [mbwr_enc_pkg::QTY_W-1:0] words_left_next;
  logic                           last_word;

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;

  // count saturation to 1..max
  always_comb begin
    if (register_qty == '0) begin
      qty_sat = mbwr_enc_pkg::QTY_W'(1);
    end else if (register_qty > mbwr_enc_pkg::QTY_W'(mbwr_enc_pkg::MAX_REGISTERS)) begin
      qty_sat = mbwr_enc_pkg::QTY_W'(mbwr_enc_pkg::MAX_REGISTERS);
    end else begin
      qty_sat = register_qty;
    end
  end

  // words still expected after this one
  always_comb begin
    if (start_req) begin
      words_left_next = qty_sat - mbwr_enc_pkg::QTY_W'(1);
    end else begin
      words_left_next = words_left - mbwr_enc_pkg::QTY_W'(1);
    end
  end

  assign last_word = (words_left_next == '0);

  // a word with no open frame is dropped
  assign push = accept && (start_req || frame_open);

  always_comb begin
    push_cmd.start     = start_req;
    push_cmd.last_word = last_word;
    push_cmd.reply     = start_req ? (slave_addr != 8'h00) : reply_flag;
    push_cmd.addr      = slave_addr;
    push_cmd.saddr     = start_addr;
    push_cmd.qty       = qty_sat;
    push_cmd.word      = data_word;
  end

  // frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      words_left <= '0;
      reply_flag <= 1'b0;
    end else if (push) begin
      words_left <= words_left_next;
      frame_open <= !last_word;
      if (start_req) begin
        reply_flag <= (slave_addr != 8'h00);
      end
    end
  end

  `MBWR_ASSERT_NXT(a_close_on_last, push && last_word, !frame_open, "frame still open after last word")
  `MBWR_ASSERT_IMP(a_open_has_words, frame_open, words_left != '0, "open frame with no words left")
  `MBWR_ASSERT_NXT(a_start_opens, push && start_req && !last_word, frame_open, "start did not open frame")

endmodule

// ===== design/mbwr_enc_queue.sv =====
// ----------------------------------------------------------------------------
// mbwr_enc_queue
// small command fifo that decouples word intake from byte serialization
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modbus_write_regs_frame_encoder_macros.svh"

module mbwr_enc_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  mbwr_enc_pkg::cmd_t      push_cmd,
  input  logic                    pop,
  output mbwr_enc_pkg::cmd_t      head_cmd,
  output mbwr_enc_pkg::q_status_t q_status
);

  mbwr_enc_pkg::cmd_t              entries [mbwr_enc_pkg::QUEUE_DEPTH];
  logic [mbwr_enc_pkg::QPTR_W-1:0] wr_ptr;
  logic [mbwr_enc_pkg::QPTR_W-1:0] rd_ptr;
  logic [mbwr_enc_pkg::QCNT_W-1:0] count;

  assign q_status.full  = (count == mbwr_enc_pkg::QCNT_W'(mbwr_enc_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign head_cmd       = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mbwr_enc_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mbwr_enc_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + mbwr_enc_pkg::QCNT_W'(1);
        2'b01:   count <= count - mbwr_enc_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `MBWR_ASSERT(a_count_range, count <= mbwr_enc_pkg::QCNT_W'(mbwr_enc_pkg::QUEUE_DEPTH), "queue overfilled")
  `MBWR_ASSERT_IMP(a_no_push_full, push, !q_status.full, "push into full queue")
  `MBWR_ASSERT_IMP(a_no_pop_empty, pop, !q_status.empty, "pop from empty queue")

endmodule

// ===== design/mbwr_enc_back.sv =====
// ----------------------------------------------------------------------------
// mbwr_enc_back
// serializes queued commands into frame bytes and runs the crc
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modbus_write_regs_frame_encoder_macros.svh"

module mbwr_enc_back (
  input  logic                    clk,
  input  logic                    rst,
  input  mbwr_enc_pkg::cmd_t      head_cmd,
  input  mbwr_enc_pkg::q_status_t q_status,
  output logic                    pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [7:0]              tx_byte,
  output logic                    last_byte,
  output logic                    reply_expected
);

  mbwr_enc_pkg::byte_sel_t state;
  mbwr_enc_pkg::byte_sel_t state_next;
  mbwr_enc_pkg::byte_sel_t cur_sel;
  logic [15:0]             crc;
  logic [15:0]             crc_base;
  logic [7:0]              byte_val;
  logic                    crc_upd;
  logic                    entry_done;
  logic                    emit;

  // a byte goes out whenever the queue holds an entry and the output register is free
  assign emit = !q_status.empty && (!m_tvalid || m_tready);

  // position of the byte for the head entry
  always_comb begin
    if (state == mbwr_enc_pkg::SEL_START) begin
      cur_sel = head_cmd.start ? mbwr_enc_pkg::SEL_ADDR : mbwr_enc_pkg::SEL_WORD_HI;
    end else begin
      cur_sel = state;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    if (emit) begin
      case (cur_sel)
        mbwr_enc_pkg::SEL_ADDR:    state_next = mbwr_enc_pkg::SEL_FUNC;
        mbwr_enc_pkg::SEL_FUNC:    state_next = mbwr_enc_pkg::SEL_SA_HI;
        mbwr_enc_pkg::SEL_SA_HI:   state_next = mbwr_enc_pkg::SEL_SA_LO;
        mbwr_enc_pkg::SEL_SA_LO:   state_next = mbwr_enc_pkg::SEL_QTY_HI;
        mbwr_enc_pkg::SEL_QTY_HI:  state_next = mbwr_enc_pkg::SEL_QTY_LO;
        mbwr_enc_pkg::SEL_QTY_LO:  state_next = mbwr_enc_pkg::SEL_BCNT;
        mbwr_enc_pkg::SEL_BCNT:    state_next = mbwr_enc_pkg::SEL_WORD_HI;
        mbwr_enc_pkg::SEL_WORD_HI: state_next = mbwr_enc_pkg::SEL_WORD_LO;
        mbwr_enc_pkg::SEL_WORD_LO: begin
          state_next = head_cmd.last_word ? mbwr_enc_pkg::SEL_CRC_LO : mbwr_enc_pkg::SEL_START;
        end
        mbwr_enc_pkg::SEL_CRC_LO:  state_next = mbwr_enc_pkg::SEL_CRC_HI;
        default:                   state_next = mbwr_enc_pkg::SEL_START;
      endcase
    end
  end

  // byte select, crc enable and entry completion
  always_comb begin
    byte_val   = 8'h00;
    crc_upd    = 1'b1;
    entry_done = 1'b0;
    case (cur_sel)
      mbwr_enc_pkg::SEL_ADDR:    byte_val = head_cmd.addr;
      mbwr_enc_pkg::SEL_FUNC:    byte_val = mbwr_enc_pkg::FUNC_WRITE_MULTI;
      mbwr_enc_pkg::SEL_SA_HI:   byte_val = head_cmd.saddr[15:8];
      mbwr_enc_pkg::SEL_SA_LO:   byte_val = head_cmd.saddr[7:0];
      mbwr_enc_pkg::SEL_QTY_HI:  byte_val = 8'h00;
      mbwr_enc_pkg::SEL_QTY_LO:  byte_val = {1'b0, head_cmd.qty};
      mbwr_enc_pkg::SEL_BCNT:    byte_val = {head_cmd.qty, 1'b0};
      mbwr_enc_pkg::SEL_WORD_HI: byte_val = head_cmd.word[15:8];
      mbwr_enc_pkg::SEL_WORD_LO: begin
        byte_val   = head_cmd.word[7:0];
        entry_done = !head_cmd.last_word;
      end
      mbwr_enc_pkg::SEL_CRC_LO: begin
        byte_val = crc[7:0];
        crc_upd  = 1'b0;
      end
      mbwr_enc_pkg::SEL_CRC_HI: begin
        byte_val   = crc[15:8];
        crc_upd    = 1'b0;
        entry_done = 1'b1;
      end
      default: begin
        byte_val = 8'h00;
        crc_upd  = 1'b0;
      end
    endcase
  end

  assign pop      = emit && entry_done;
  assign crc_base = (cur_sel == mbwr_enc_pkg::SEL_ADDR) ? mbwr_enc_pkg::CRC_INIT : crc;

  // sequencer and crc
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbwr_enc_pkg::SEL_START;
      crc   <= mbwr_enc_pkg::CRC_INIT;
    end else begin
      state <= state_next;
      if (emit && crc_upd) begin
        crc <= mbwr_enc_pkg::crc_byte(crc_base, byte_val);
      end else if (emit && cur_sel == mbwr_enc_pkg::SEL_CRC_HI) begin
        crc <= mbwr_enc_pkg::CRC_INIT;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tx_byte        <= byte_val;
      last_byte      <= (cur_sel == mbwr_enc_pkg::SEL_CRC_HI);
      reply_expected <= head_cmd.reply;
    end
  end

  `MBWR_ASSERT_IMP(a_crc_only_last, emit && cur_sel == mbwr_enc_pkg::SEL_CRC_LO,
                   head_cmd.last_word, "crc emitted for a word that does not close the frame")
  `MBWR_ASSERT_IMP(a_idle_at_start, q_status.empty, state == mbwr_enc_pkg::SEL_START,
                   "sequencer mid-entry with empty queue")
  `MBWR_ASSERT_NXT(a_crc_lo_then_hi, emit && cur_sel == mbwr_enc_pkg::SEL_CRC_LO,
                   state == mbwr_enc_pkg::SEL_CRC_HI, "crc low byte not followed by high byte")

endmodule

// ===== design/modbus_write_regs_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// modbus_write_regs_frame_encoder
// modbus rtu write multiple registers frame builder with crc-16 trailer
//
//   channel  dir  tdata (lsb up)                                 tuser      tlast
//   s_*      in   slave_addr, start_addr, register_qty, data_word start_req  -
//   m_*      out  tx_byte                                        reply_exp  last_byte
//
// one output byte per cycle from a single output register unless stalled: a data word
// gives 2 bytes, a closing word 4, a start word 9 (11 for a one-register frame)
// a word arriving with no open frame is accepted and makes no beat
// a 4-entry command queue lets input beats continue while the output stalls
// synchronous active-high reset empties the queue and closes any frame
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_write_regs_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // slave_addr[7:0], start_addr[23:8], register_qty[30:24],
                                 // data_word[46:31], zero pad[47]
  input  logic        s_tuser,   // start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // tx_byte
  output logic        m_tlast,   // last_byte
  output logic        m_tuser    // reply_expected
);

  logic                    push;
  logic                    pop;
  mbwr_enc_pkg::cmd_t      push_cmd;
  mbwr_enc_pkg::cmd_t      head_cmd;
  mbwr_enc_pkg::q_status_t q_status;

  // intake and classification
  mbwr_enc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .start_req    (s_tuser),
    .slave_addr   (s_tdata[7:0]),
    .start_addr   (s_tdata[23:8]),
    .register_qty (s_tdata[30:24]),
    .data_word    (s_tdata[46:31]),
    .q_status     (q_status),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // command queue
  mbwr_enc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_status (q_status)
  );

  // byte serializer
  mbwr_enc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_cmd       (head_cmd),
    .q_status       (q_status),
    .pop            (pop),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .tx_byte        (m_tdata),
    .last_byte      (m_tlast),
    .reply_expected (m_tuser)
  );

endmodule

// ===== bench/modbus_write_regs_frame_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// modbus_write_regs_frame_encoder_tb
// drives register words into the encoder and checks every frame byte against
// a behavioral copy of the frame builder and its crc-16 trailer, under
// random source gaps and sink back-pressure
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_write_regs_frame_encoder_tb;

  // one expected output beat
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       reply_expected;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // slave_addr, start_addr, register_qty, data_word, pad
  logic        s_tuser = 1'b0; // start_req
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // tx_byte
  logic        m_tlast;        // last_byte
  logic        m_tuser;        // reply_expected

  // frame builder mirror
  logic [15:0] crc_acc = mbwr_enc_pkg::CRC_INIT;
  logic [6:0]  words_remaining = '0;
  logic        frame_reply = 1'b0;
  logic        frame_in_progress = 1'b0;

  frame_byte_t frame_bytes_due[$];
  frame_byte_t next_due;
  int          mismatch_count = 0;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;

  modbus_write_regs_frame_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bit-serial crc-16/modbus, lsb of the byte first
  function automatic logic [15:0] crc16_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int k = 0; k < 8; k++) begin
      fb  = acc[0] ^ b[k];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ mbwr_enc_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic last);
    frame_byte_t fb;
    fb.tx_byte        = b;
    fb.last_byte      = last;
    fb.reply_expected = frame_reply;
    frame_bytes_due.push_back(fb);
    crc_acc = crc16_add_byte(crc_acc, b);
  endfunction

  // expected bytes for one accepted word
  function automatic void encode_word(input logic start, input logic [7:0] addr,
                                      input logic [15:0] saddr, input logic [6:0] qty_field,
                                      input logic [15:0] word);
    logic [6:0]  qty;
    logic [15:0] frame_crc;
    if (start) begin
      qty = qty_field;
      if (qty == 0) begin
        qty = 7'd1;
      end else if (qty > mbwr_enc_pkg::MAX_REGISTERS) begin
        qty = 7'(mbwr_enc_pkg::MAX_REGISTERS);
      end
      crc_acc           = mbwr_enc_pkg::CRC_INIT;
      frame_reply       = (addr != 8'h00);
      frame_in_progress = 1'b1;
      queue_byte(addr, 1'b0);
      queue_byte(mbwr_enc_pkg::FUNC_WRITE_MULTI, 1'b0);
      queue_byte(saddr[15:8], 1'b0);
      queue_byte(saddr[7:0], 1'b0);
      // count high byte is always zero for counts up to 123
      queue_byte(8'h00, 1'b0);
      queue_byte({1'b0, qty}, 1'b0);
      queue_byte({qty, 1'b0}, 1'b0);
      words_remaining = qty - 7'd1;
    end else begin
      // stray word outside a frame is dropped
      if (!frame_in_progress) begin
        return;
      end
      words_remaining = words_remaining - 7'd1;
    end
    queue_byte(word[15:8], 1'b0);
    queue_byte(word[7:0], 1'b0);
    if (words_remaining == 0) begin
      frame_crc = crc_acc;
      queue_byte(frame_crc[7:0], 1'b0);
      queue_byte(frame_crc[15:8], 1'b1);
      crc_acc           = mbwr_enc_pkg::CRC_INIT;
      frame_in_progress = 1'b0;
    end
  endfunction

  // one input beat, with a random gap ahead of it; returns at the accepting edge
  task automatic send_word(input logic start, input logic [7:0] addr, input logic [15:0] saddr,
                           input logic [6:0] qty_field, input logic [15:0] word);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= start;
    s_tdata  <= {1'b0, word, qty_field, saddr, addr};
    do @(posedge clk); while (!s_tready);
    encode_word(start, addr, saddr, qty_field, word);
  endtask

  // sink back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // output beat checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (frame_bytes_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got tx_byte %02h last %0b reply %0b",
                 $time, m_tdata, m_tlast, m_tuser);
        mismatch_count++;
      end else begin
        next_due = frame_bytes_due.pop_front();
        if (m_tdata !== next_due.tx_byte) begin
          $display("%0t: tx_byte expected %02h got %02h", $time, next_due.tx_byte, m_tdata);
          mismatch_count++;
        end
        if (m_tlast !== next_due.last_byte) begin
          $display("%0t: last_byte expected %0b got %0b", $time, next_due.last_byte, m_tlast);
          mismatch_count++;
        end
        if (m_tuser !== next_due.reply_expected) begin
          $display("%0t: reply_expected expected %0b got %0b",
                   $time, next_due.reply_expected, m_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // one-word frames at the field extremes
  task automatic test_single_register_frame();
    send_word(1'b1, 8'd1, 16'h0000, 7'd1, 16'h0000);
    send_word(1'b1, 8'd247, 16'hFFFF, 7'd1, 16'hFFFF);
  endtask

  // broadcast clears the reply flag, addresses above 247 still set it
  task automatic test_address_range();
    send_word(1'b1, 8'd0, 16'h1234, 7'd2, 16'hA5A5);
    send_word(1'b0, 8'hFF, 16'hFFFF, 7'h7F, 16'h5A5A);
    send_word(1'b1, 8'd255, 16'h8001, 7'd1, 16'h8001);
  endtask

  // zero and oversize counts clamp to the legal range
  task automatic test_count_saturation();
    send_word(1'b1, 8'd17, 16'h0100, 7'd0, 16'hC0DE);
    send_word(1'b1, 8'd18, 16'h0200, 7'd127, 16'h1111);
    send_word(1'b0, 8'd0, 16'h0000, 7'd0, 16'h2222);
    send_word(1'b1, 8'd19, 16'h0300, 7'd124, 16'h3333);
    send_word(1'b0, 8'd0, 16'h0000, 7'd0, 16'h4444);
    send_word(1'b1, 8'd20, 16'h0400, 7'd123, 16'h5555);
    send_word(1'b1, 8'd21, 16'h0500, 7'd2, 16'h6666);
    send_word(1'b0, 8'd0, 16'h0000, 7'd0, 16'h7777);
  endtask

  // a new start drops the open frame without a trailer
  task automatic test_abandoned_frame();
    send_word(1'b1, 8'd33, 16'h7FFF, 7'd4, 16'h0F0F);
    send_word(1'b0, 8'd0, 16'h0000, 7'd0, 16'hF0F0);
    send_word(1'b1, 8'd34, 16'h0001, 7'd2, 16'h00FF);
    send_word(1'b0, 8'd0, 16'h0000, 7'd0, 16'hFF00);
  endtask

  // words with no frame open make no beats
  task automatic test_stray_words();
    send_word(1'b0, 8'd5, 16'hAAAA, 7'd3, 16'hDEAD);
    send_word(1'b0, 8'd6, 16'h5555, 7'd9, 16'hBEEF);
    send_word(1'b1, 8'd7, 16'h0042, 7'd1, 16'h0042);
  endtask

  // mostly complete frames, some cut short or oversize, some stray words
  task automatic test_random_frames(input int src_pct, input int sink_pct, input int n_words);
    int         sent;
    int         pick;
    int         qty;
    int         words;
    logic [6:0] qty_field;
    logic [7:0] addr;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(99);
      if (pick < 8 && !frame_in_progress) begin
        send_word(1'b0, 8'($urandom), 16'($urandom), 7'($urandom), 16'($urandom));
      end else begin
        addr = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
        if (pick < 80) begin
          qty = ($urandom_range(9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
          qty_field = 7'(qty);
          if ($urandom_range(19) == 0) begin
            qty_field = 7'd0;
            qty       = 1;
          end
          words = qty;
        end else begin
          qty_field = 7'($urandom_range(0, 127));
          qty = (qty_field == 0) ? 1 :
                (qty_field > mbwr_enc_pkg::MAX_REGISTERS) ? mbwr_enc_pkg::MAX_REGISTERS :
                qty_field;
          words = $urandom_range(1, (qty < 5) ? qty : 5);
        end
        send_word(1'b1, addr, 16'($urandom), qty_field, 16'($urandom));
        for (int w = 1; w < words; w++) begin
          send_word(1'b0, 8'($urandom), 16'($urandom), 7'($urandom), 16'($urandom));
        end
        sent += words;
      end
    end
  endtask

  initial begin
    src_idle_pct  = 14;
    sink_idle_pct = 82;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_single_register_frame();
    test_address_range();
    test_count_saturation();
    test_abandoned_frame();
    test_stray_words();
    test_random_frames(14, 82, 85);
    test_random_frames(82, 14, 85);
    test_random_frames(0, 0, 80);
    s_tvalid <= 1'b0;

    // drain, then watch for stray beats
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
